FILE: sv/tte_pkg.sv
// tte_pkg: shared types and constants of the text terminal engine
// no dependencies; imported by every module of the block

package tte_pkg;

    // field widths
    localparam int MODE_W     = 4;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 16;
    localparam int CELL_W     = 11;
    localparam int LOG_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 56;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // input modes
    localparam logic [MODE_W-1:0] MODE_PUT   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 4'd1;
    localparam logic [MODE_W-1:0] MODE_LEFT  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 4'd3;
    localparam logic [MODE_W-1:0] MODE_UP    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DOWN  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ON    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_OFF   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_TICK  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_READ  = 4'd9;

    // special characters
    localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [CHAR_W-1:0] BLINK_BIT = 8'h80;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_LOG2    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_LOG2       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_BACKGROUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL  = 3'd5;

    // configuration reset values
    localparam logic [2:0]         RST_COLUMNS_LOG2    = 3'd6;
    localparam logic [2:0]         RST_ROWS_LOG2       = 3'd5;
    localparam logic [COLOR_W-1:0] RST_FILL_COLOR      = 16'hFFFF;
    localparam logic [COLOR_W-1:0] RST_FILL_BACKGROUND = 16'h0000;
    localparam logic [COLOR_W-1:0] RST_TEXT_COLOR      = 16'hFFFF;
    localparam logic [CHAR_W-1:0]  RST_BLINK_INTERVAL  = 8'd20;

    // classified operations
    typedef enum logic [3:0] {
        OP_PUT,
        OP_CR,
        OP_LF,
        OP_CLEAR,
        OP_LEFT,
        OP_RIGHT,
        OP_UP,
        OP_DOWN,
        OP_ON,
        OP_OFF,
        OP_TICK,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  symbol;
        logic [CELL_W-1:0]  cell_index;
    } cmd_t;

    // queue status toward the front part
    typedef struct packed {
        logic full;
    } q_stat_t;

    // queue head toward the back part
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    // back part sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_CLEAR,
        ST_SCROLL,
        ST_DRAIN,
        ST_BLANK,
        ST_DONE
    } state_t;

endpackage

FILE: sv/tte_front.sv
// tte_front: accepts input transactions and classifies them into commands
// depends on tte_pkg; feeds tte_queue

module tte_front import tte_pkg::*; (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // symbol [7:0], cell_index [18:8], zero pad
    input  logic [MODE_W-1:0]   s_tuser,   // mode [3:0]
    input  q_stat_t             q_stat,
    output logic                push,
    output cmd_t                push_cmd
);

    logic [CHAR_W-1:0] symbol;
    op_t               op;

    assign symbol   = s_tdata[CHAR_W-1:0];
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    // decode mode and special characters
    always_comb begin
        unique case (s_tuser)
            MODE_PUT: begin
                if (symbol == CH_CR) begin
                    op = OP_CR;
                end else if (symbol == CH_LF) begin
                    op = OP_LF;
                end else begin
                    op = OP_PUT;
                end
            end
            MODE_CLEAR: op = OP_CLEAR;
            MODE_LEFT:  op = OP_LEFT;
            MODE_RIGHT: op = OP_RIGHT;
            MODE_UP:    op = OP_UP;
            MODE_DOWN:  op = OP_DOWN;
            MODE_ON:    op = OP_ON;
            MODE_OFF:   op = OP_OFF;
            MODE_TICK:  op = OP_TICK;
            MODE_READ:  op = OP_READ;
            default:    op = OP_NOP;
        endcase
    end

    assign push_cmd.op         = op;
    assign push_cmd.symbol     = symbol;
    assign push_cmd.cell_index = s_tdata[CHAR_W+CELL_W-1:CHAR_W];

endmodule

FILE: sv/tte_queue.sv
// tte_queue: short command queue between the front and back parts
// depends on tte_pkg

module tte_queue import tte_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_cmd,
    output q_stat_t q_stat,
    input  logic    pop,
    output q_head_t q_head
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_head.valid = (count_reg != '0);
    assign q_head.cmd   = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_head.valid |-> !pop) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: sv/tte_back.sv
// tte_back: executes commands on the cell stores, cursor and blink state
// depends on tte_pkg; holds the configuration registers and the result register

module tte_back import tte_pkg::*; #(
    parameter int TILES_LOG2 = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  q_head_t               q_head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam int AW    = TILES_LOG2;
    localparam int CW    = TILES_LOG2 + 1;
    localparam int DEPTH = 1 << TILES_LOG2;

    // configuration registers
    logic [2:0]         columns_log2_reg;
    logic [2:0]         rows_log2_reg;
    logic [COLOR_W-1:0] fill_color_reg;
    logic [COLOR_W-1:0] fill_background_reg;
    logic [COLOR_W-1:0] text_color_reg;
    logic [CHAR_W-1:0]  blink_interval_reg;

    // cell stores
    logic [CHAR_W-1:0]  char_mem  [DEPTH];
    logic [COLOR_W-1:0] color_mem [DEPTH];
    logic [COLOR_W-1:0] bg_mem    [DEPTH];
    logic [CHAR_W-1:0]  rd_char_reg;
    logic [COLOR_W-1:0] rd_color_reg;
    logic [COLOR_W-1:0] rd_bg_reg;

    // memory port controls
    logic               we_char;
    logic               we_color;
    logic               we_bg;
    logic [AW-1:0]      wr_addr;
    logic [CHAR_W-1:0]  wr_char;
    logic [COLOR_W-1:0] wr_color;
    logic [COLOR_W-1:0] wr_bg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    // sequencer state
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      dst_reg, dst_next;
    logic [AW-1:0]      cursor_reg, cursor_next;
    logic [CHAR_W-1:0]  countdown_reg, countdown_next;
    logic               blink_reg, blink_next;
    logic [CHAR_W-1:0]  saved_reg, saved_next;
    logic [CHAR_W-1:0]  res_char_reg, res_char_next;
    logic [COLOR_W-1:0] res_color_reg, res_color_next;
    logic [COLOR_W-1:0] res_bg_reg, res_bg_next;
    logic               out_load;

    // result register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // grid geometry
    logic [LOG_W-1:0] cols_log2_eff;
    logic [LOG_W-1:0] room;
    logic [LOG_W-1:0] rows_log2_eff;
    logic [LOG_W-1:0] cells_log2;
    logic [CW-1:0]    cells_cnt;
    logic [CW-1:0]    cols_cnt;
    logic [AW-1:0]    cell_mask;
    logic [AW-1:0]    col_mask;
    logic [AW-1:0]    cols_a;
    logic [AW-1:0]    cur_m;
    logic [AW-1:0]    lf_base;
    logic             last_idx;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_log2_reg    <= RST_COLUMNS_LOG2;
            rows_log2_reg       <= RST_ROWS_LOG2;
            fill_color_reg      <= RST_FILL_COLOR;
            fill_background_reg <= RST_FILL_BACKGROUND;
            text_color_reg      <= RST_TEXT_COLOR;
            blink_interval_reg  <= RST_BLINK_INTERVAL;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COLUMNS_LOG2:    columns_log2_reg    <= cfg_data[2:0];
                CFG_ROWS_LOG2:       rows_log2_reg       <= cfg_data[2:0];
                CFG_FILL_COLOR:      fill_color_reg      <= cfg_data;
                CFG_FILL_BACKGROUND: fill_background_reg <= cfg_data;
                CFG_TEXT_COLOR:      text_color_reg      <= cfg_data;
                CFG_BLINK_INTERVAL:  blink_interval_reg  <= cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // columns clipped to the store, rows clipped to what is left
    always_comb begin
        cols_log2_eff = (LOG_W'(columns_log2_reg) > LOG_W'(TILES_LOG2)) ?
                        LOG_W'(TILES_LOG2) : LOG_W'(columns_log2_reg);
        room          = LOG_W'(TILES_LOG2) - cols_log2_eff;
        rows_log2_eff = (LOG_W'(rows_log2_reg) > room) ? room : LOG_W'(rows_log2_reg);
        cells_log2    = cols_log2_eff + rows_log2_eff;
        cells_cnt     = CW'(1) << cells_log2;
        cols_cnt      = CW'(1) << cols_log2_eff;
        cell_mask     = AW'(cells_cnt - CW'(1));
        col_mask      = AW'(cols_cnt - CW'(1));
        cols_a        = AW'(cols_cnt);
        cur_m         = cursor_reg & cell_mask;
        lf_base       = cur_m & ~col_mask;
        last_idx      = (idx_reg == cells_cnt - CW'(1));
    end

    // cell stores: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we_char) begin
            char_mem[wr_addr] <= wr_char;
        end
        if (we_color) begin
            color_mem[wr_addr] <= wr_color;
        end
        if (we_bg) begin
            bg_mem[wr_addr] <= wr_bg;
        end
        if (rd_en) begin
            rd_char_reg  <= char_mem[rd_addr];
            rd_color_reg <= color_mem[rd_addr];
            rd_bg_reg    <= bg_mem[rd_addr];
        end
    end

    // sequencer next state and memory controls
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        dst_next       = dst_reg;
        cursor_next    = cursor_reg;
        countdown_next = countdown_reg;
        blink_next     = blink_reg;
        saved_next     = saved_reg;
        res_char_next  = res_char_reg;
        res_color_next = res_color_reg;
        res_bg_next    = res_bg_reg;
        pop            = 1'b0;
        out_load       = 1'b0;
        we_char        = 1'b0;
        we_color       = 1'b0;
        we_bg          = 1'b0;
        wr_addr        = '0;
        wr_char        = '0;
        wr_color       = '0;
        wr_bg          = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_head.valid) begin
                    pop            = 1'b1;
                    op_next        = q_head.cmd.op;
                    cursor_next    = cur_m;
                    res_char_next  = '0;
                    res_color_next = '0;
                    res_bg_next    = '0;
                    state_next     = ST_DONE;
                    unique case (q_head.cmd.op)
                        OP_PUT: begin
                            we_char     = 1'b1;
                            we_color    = 1'b1;
                            wr_addr     = cur_m;
                            wr_char     = q_head.cmd.symbol;
                            wr_color    = text_color_reg;
                            cursor_next = (cur_m + AW'(1)) & cell_mask;
                        end
                        OP_CR: cursor_next = lf_base;
                        OP_LF: begin
                            if (CW'(lf_base) + cols_cnt >= cells_cnt) begin
                                // last row: scroll, cursor stays at row start
                                cursor_next = lf_base;
                                if (cols_cnt == cells_cnt) begin
                                    idx_next   = '0;
                                    state_next = ST_BLANK;
                                end else begin
                                    idx_next   = cols_cnt;
                                    state_next = ST_SCROLL;
                                end
                            end else begin
                                cursor_next = lf_base + cols_a;
                            end
                        end
                        OP_CLEAR: begin
                            idx_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_LEFT:  cursor_next = (cur_m - AW'(1)) & cell_mask;
                        OP_RIGHT: cursor_next = (cur_m + AW'(1)) & cell_mask;
                        OP_UP:    cursor_next = (cur_m - cols_a) & cell_mask;
                        OP_DOWN:  cursor_next = (cur_m + cols_a) & cell_mask;
                        OP_ON: begin
                            rd_en      = 1'b1;
                            rd_addr    = cur_m;
                            state_next = ST_WAIT;
                        end
                        OP_OFF: begin
                            blink_next = 1'b0;
                            we_char    = 1'b1;
                            wr_addr    = cur_m;
                            wr_char    = saved_reg;
                        end
                        OP_TICK: begin
                            if (blink_reg) begin
                                if (countdown_reg == '0) begin
                                    rd_en          = 1'b1;
                                    rd_addr        = cur_m;
                                    countdown_next = blink_interval_reg - CHAR_W'(1);
                                    state_next     = ST_WAIT;
                                end else begin
                                    countdown_next = countdown_reg - CHAR_W'(1);
                                end
                            end
                        end
                        OP_READ: begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(q_head.cmd.cell_index);
                            state_next = ST_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WAIT: begin
                // read data of the previous cycle is now registered
                unique case (op_reg)
                    OP_ON: begin
                        saved_next     = rd_char_reg;
                        blink_next     = 1'b1;
                        countdown_next = '0;
                    end
                    OP_TICK: begin
                        we_char = 1'b1;
                        wr_addr = cursor_reg;
                        wr_char = rd_char_reg ^ BLINK_BIT;
                    end
                    OP_READ: begin
                        res_char_next  = rd_char_reg;
                        res_color_next = rd_color_reg;
                        res_bg_next    = rd_bg_reg;
                    end
                    default: ;
                endcase
                state_next = ST_DONE;
            end
            ST_CLEAR: begin
                we_char  = 1'b1;
                we_color = 1'b1;
                we_bg    = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                wr_char  = CH_SPACE;
                wr_color = fill_color_reg;
                wr_bg    = fill_background_reg;
                idx_next = idx_reg + CW'(1);
                if (last_idx) begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL: begin
                // read one row below, write back the cell whose read data is now registered
                rd_en     = 1'b1;
                rd_addr   = idx_reg[AW-1:0];
                pend_next = 1'b1;
                dst_next  = AW'(idx_reg - cols_cnt);
                if (pend_reg) begin
                    we_char  = 1'b1;
                    we_color = 1'b1;
                    we_bg    = 1'b1;
                    wr_addr  = dst_reg;
                    wr_char  = rd_char_reg;
                    wr_color = rd_color_reg;
                    wr_bg    = rd_bg_reg;
                end
                idx_next = idx_reg + CW'(1);
                if (last_idx) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pend_reg) begin
                    we_char  = 1'b1;
                    we_color = 1'b1;
                    we_bg    = 1'b1;
                    wr_addr  = dst_reg;
                    wr_char  = rd_char_reg;
                    wr_color = rd_color_reg;
                    wr_bg    = rd_bg_reg;
                end
                idx_next   = cells_cnt - cols_cnt;
                state_next = ST_BLANK;
            end
            ST_BLANK: begin
                // new bottom row gets spaces, colors stay
                we_char  = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                wr_char  = CH_SPACE;
                idx_next = idx_reg + CW'(1);
                if (last_idx) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            cursor_reg    <= '0;
            countdown_reg <= '0;
            blink_reg     <= 1'b0;
            saved_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            cursor_reg    <= cursor_next;
            countdown_reg <= countdown_next;
            blink_reg     <= blink_next;
            saved_reg     <= saved_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        dst_reg       <= dst_next;
        res_char_reg  <= res_char_next;
        res_color_reg <= res_color_next;
        res_bg_reg    <= res_bg_next;
    end

    // result register toward the output channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {4'b0000, blink_reg, CELL_W'(cursor_reg),
                           res_bg_reg, res_color_reg, res_char_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_cursor_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> ((cursor_reg & ~cell_mask) == '0))
        else $error("cursor outside grid at item end");
    a_done_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_tready)) |=> m_valid_reg)
        else $error("finished item not delivered");
    a_pend_in_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_SCROLL || state_reg == ST_DRAIN))
        else $error("scroll write pending outside scroll");
    a_idle_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !q_head.valid) |=> (state_reg == ST_IDLE))
        else $error("sequencer left idle without a command");
`endif

endmodule

FILE: sv/text_terminal_engine.sv
// text_terminal_engine: top level of the character-cell terminal
// depends on tte_pkg, tte_front, tte_queue and tte_back
//
// channel   direction  handshake                  payload
// s_*       in         s_tvalid / s_tready        tdata: symbol, cell_index; tuser: mode
// m_*       out        m_tvalid / m_tready        tdata: char, color, background, cursor, blink
// cfg_*     in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Items run one at a time over the cell stores, one read and one write per cycle.
// Put, CR, LF without scroll, moves, cursor off, quiet ticks go straight to done; read,
// cursor on, blink-toggling ticks wait on the read; clear writes all grid cells; LF with scroll
// moves any rows up, blanks the bottom row. Up to two items queue while the back is busy;
// a finished item holds the back only while an untaken result sits in the output register.
// Reset is synchronous, active low; stores hold no reset value until cleared.

module text_terminal_engine import tte_pkg::*; #(
    parameter int TILES_LOG2 = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // symbol [7:0], cell_index [18:8], zero pad
    input  logic [MODE_W-1:0]     s_tuser,   // mode [3:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // cell_char [7:0], cell_color [23:8],
                                             // cell_background [39:24], cursor_index [50:40],
                                             // blink_active [51], zero pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    q_stat_t q_stat;
    q_head_t q_head;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;

    // accept and classify
    tte_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // command queue
    tte_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .q_head   (q_head)
    );

    // execution
    tte_back #(
        .TILES_LOG2 (TILES_LOG2)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_head    (q_head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: tb/text_terminal_engine_tb.sv
// text_terminal_engine_tb: self-checking testbench for the character-cell terminal
// depends on tte_pkg and text_terminal_engine; a shadow terminal predicts every result not fixed in the script
// directed opening rows, then randomized phases over several grid and color settings

module text_terminal_engine_tb;
    import tte_pkg::*;

    localparam int TILES_LOG2      = 11;
    localparam int STORE_DEPTH     = 1 << TILES_LOG2;
    localparam int RESET_CYCLES    = 7;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int SCRIPT_ROWS     = 26;

    // modes the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE_LOW = MODE_READ + 1'b1;
    localparam logic [MODE_W-1:0] MODE_SPARE_TOP = {MODE_W{1'b1}};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] symbol;
        logic [CELL_W-1:0] cell_index;
    } term_cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] background;
        logic [CELL_W-1:0]  cursor;
        logic               blink;
    } cell_view_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] symbol;
        logic [CELL_W-1:0] cell_index;
        logic              typed;
        cell_view_t        want;
    } script_row_t;

    typedef struct packed {
        logic [2:0]         cols_log2;
        logic [2:0]         rows_log2;
        logic [COLOR_W-1:0] fill_fg;
        logic [COLOR_W-1:0] fill_bg;
        logic [COLOR_W-1:0] text_fg;
        logic [CHAR_W-1:0]  interval;
    } reg_setting_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // symbol [7:0], cell_index [18:8], zero pad
    logic [MODE_W-1:0]     s_tuser;   // mode [3:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // cell_char [7:0], cell_color [23:8],
                                      // cell_background [39:24], cursor_index [50:40],
                                      // blink_active [51], zero pad
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    text_terminal_engine #(.TILES_LOG2(TILES_LOG2)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow terminal state
    logic [CHAR_W-1:0]  glyph_mem [STORE_DEPTH];
    logic [COLOR_W-1:0] fg_mem    [STORE_DEPTH];
    logic [COLOR_W-1:0] bg_mem    [STORE_DEPTH];
    int unsigned        cursor_at;
    logic [CHAR_W-1:0]  blink_count;
    logic               blink_en;
    logic [CHAR_W-1:0]  saved_glyph;

    // shadow registers
    int unsigned        geo_cols_log2;
    int unsigned        geo_rows_log2;
    logic [COLOR_W-1:0] clear_fg;
    logic [COLOR_W-1:0] clear_bg;
    logic [COLOR_W-1:0] ink_fg;
    logic [CHAR_W-1:0]  blink_period;

    cell_view_t expected_views [$];
    int         fail_count = 0;
    int         idle_cycles = 0;

    // directed opening: fixed answers only where obvious
    script_row_t opening_script [SCRIPT_ROWS] = '{
        '{MODE_RIGHT, 8'h00, 11'd0, 1'b1, '{8'h00, 16'h0000, 16'h0000, 11'd1, 1'b0}},
        '{MODE_LEFT,  8'h00, 11'd0, 1'b1, '{8'h00, 16'h0000, 16'h0000, 11'd0, 1'b0}},
        '{MODE_LEFT,  8'h00, 11'd0, 1'b1, '{8'h00, 16'h0000, 16'h0000, 11'd2047, 1'b0}},
        '{MODE_CLEAR, 8'h00, 11'd0, 1'b1, '{8'h00, 16'h0000, 16'h0000, 11'd2047, 1'b0}},
        '{MODE_READ,  8'h00, 11'd0, 1'b1,
          '{CH_SPACE, RST_FILL_COLOR, RST_FILL_BACKGROUND, 11'd2047, 1'b0}},
        '{MODE_READ,  8'h00, 11'd2047, 1'b1,
          '{CH_SPACE, RST_FILL_COLOR, RST_FILL_BACKGROUND, 11'd2047, 1'b0}},
        '{MODE_SPARE_TOP, 8'hFF, 11'd2047, 1'b1,
          '{8'h00, 16'h0000, 16'h0000, 11'd2047, 1'b0}},
        '{MODE_PUT,   8'h41, 11'd0, 1'b0, '0},
        '{MODE_PUT,   8'hFF, 11'd0, 1'b0, '0},
        '{MODE_PUT,   8'h00, 11'd0, 1'b0, '0},
        '{MODE_READ,  8'h00, 11'd2047, 1'b0, '0},
        '{MODE_PUT,   CH_CR, 11'd0, 1'b0, '0},
        '{MODE_PUT,   CH_LF, 11'd0, 1'b0, '0},
        '{MODE_UP,    8'h00, 11'd0, 1'b0, '0},
        '{MODE_UP,    8'h00, 11'd0, 1'b0, '0},
        '{MODE_PUT,   CH_LF, 11'd0, 1'b0, '0},
        '{MODE_READ,  8'h00, 11'd1984, 1'b0, '0},
        '{MODE_READ,  8'h00, 11'd1920, 1'b0, '0},
        '{MODE_DOWN,  8'h00, 11'd0, 1'b0, '0},
        '{MODE_ON,    8'h00, 11'd0, 1'b0, '0},
        '{MODE_TICK,  8'h00, 11'd0, 1'b0, '0},
        '{MODE_TICK,  8'h00, 11'd0, 1'b0, '0},
        '{MODE_READ,  8'h00, 11'd0, 1'b0, '0},
        '{MODE_OFF,   8'h00, 11'd0, 1'b0, '0},
        '{MODE_READ,  8'h00, 11'd0, 1'b0, '0},
        '{MODE_SPARE_LOW, 8'h5A, 11'd1365, 1'b0, '0}
    };

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // grid geometry of the shadow terminal
    function automatic int unsigned col_bits();
        return (geo_cols_log2 > TILES_LOG2) ? TILES_LOG2 : geo_cols_log2;
    endfunction

    function automatic int unsigned grid_cell_count();
        int unsigned cb, room, rb;
        cb   = col_bits();
        room = TILES_LOG2 - cb;
        rb   = (geo_rows_log2 > room) ? room : geo_rows_log2;
        return 1 << (cb + rb);
    endfunction

    function automatic void reset_shadow();
        foreach (glyph_mem[i]) begin
            glyph_mem[i] = '0;
            fg_mem[i]    = '0;
            bg_mem[i]    = '0;
        end
        cursor_at     = 0;
        blink_count   = '0;
        blink_en      = 1'b0;
        saved_glyph   = '0;
        geo_cols_log2 = 32'(RST_COLUMNS_LOG2);
        geo_rows_log2 = 32'(RST_ROWS_LOG2);
        clear_fg      = RST_FILL_COLOR;
        clear_bg      = RST_FILL_BACKGROUND;
        ink_fg        = RST_TEXT_COLOR;
        blink_period  = RST_BLINK_INTERVAL;
    endfunction

    function automatic void shadow_register(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_COLUMNS_LOG2:    geo_cols_log2 = 32'(val[2:0]);
            CFG_ROWS_LOG2:       geo_rows_log2 = 32'(val[2:0]);
            CFG_FILL_COLOR:      clear_fg      = val;
            CFG_FILL_BACKGROUND: clear_bg      = val;
            CFG_TEXT_COLOR:      ink_fg        = val;
            CFG_BLINK_INTERVAL:  blink_period  = val[CHAR_W-1:0];
            default: ;
        endcase
    endfunction

    // move rows up by one, blank the characters of the new bottom row
    function automatic void scroll_grid(input int unsigned cells, input int unsigned cols);
        int unsigned i;
        for (i = 0; i + cols < cells; i++) begin
            glyph_mem[i] = glyph_mem[i + cols];
            fg_mem[i]    = fg_mem[i + cols];
            bg_mem[i]    = bg_mem[i + cols];
        end
        for (i = cells - cols; i < cells; i++)
            glyph_mem[i] = CH_SPACE;
    endfunction

    // apply one command to the shadow terminal and return its result
    function automatic cell_view_t terminal_step(input term_cmd_t c);
        cell_view_t  v;
        int unsigned cols, cells, mask, i;
        cols  = 1 << col_bits();
        cells = grid_cell_count();
        mask  = cells - 1;
        v     = '0;
        cursor_at = cursor_at & mask;
        case (c.mode)
            MODE_PUT: begin
                if (c.symbol == CH_CR) begin
                    cursor_at -= cursor_at & (cols - 1);
                end else if (c.symbol == CH_LF) begin
                    cursor_at -= cursor_at & (cols - 1);
                    if (cursor_at + cols >= cells)
                        scroll_grid(cells, cols);
                    else
                        cursor_at += cols;
                end else begin
                    glyph_mem[cursor_at] = c.symbol;
                    fg_mem[cursor_at]    = ink_fg;
                    cursor_at            = (cursor_at + 1) & mask;
                end
            end
            MODE_CLEAR: begin
                for (i = 0; i < cells; i++) begin
                    glyph_mem[i] = CH_SPACE;
                    fg_mem[i]    = clear_fg;
                    bg_mem[i]    = clear_bg;
                end
            end
            MODE_LEFT:  cursor_at = (cursor_at - 1) & mask;
            MODE_RIGHT: cursor_at = (cursor_at + 1) & mask;
            MODE_UP:    cursor_at = (cursor_at - cols) & mask;
            MODE_DOWN:  cursor_at = (cursor_at + cols) & mask;
            MODE_ON: begin
                saved_glyph = glyph_mem[cursor_at];
                blink_en    = 1'b1;
                blink_count = '0;
            end
            MODE_OFF: begin
                blink_en             = 1'b0;
                glyph_mem[cursor_at] = saved_glyph;
            end
            MODE_TICK: begin
                if (blink_en) begin
                    if (blink_count == '0) begin
                        glyph_mem[cursor_at] = glyph_mem[cursor_at] ^ BLINK_BIT;
                        blink_count          = blink_count + blink_period;
                    end
                    blink_count = blink_count - 1'b1;
                end
            end
            MODE_READ: begin
                v.char_code  = glyph_mem[c.cell_index];
                v.color      = fg_mem[c.cell_index];
                v.background = bg_mem[c.cell_index];
            end
            default: ;
        endcase
        v.cursor = cursor_at[CELL_W-1:0];
        v.blink  = blink_en;
        return v;
    endfunction

    // one random command, weighted toward printing, moves, ticks and reads
    function automatic term_cmd_t draw_command();
        term_cmd_t   c;
        int unsigned pick, cells;
        cells        = grid_cell_count();
        c.symbol     = CHAR_W'($urandom_range(0, 255));
        c.cell_index = CELL_W'($urandom_range(0, STORE_DEPTH - 1));
        pick         = $urandom_range(0, 99);
        if (pick < 30) begin
            c.mode = MODE_PUT;
        end else if (pick < 36) begin
            c.mode   = MODE_PUT;
            c.symbol = pick[0] ? CH_CR : CH_LF;
        end else if (pick < 38) begin
            c.mode = MODE_CLEAR;
        end else if (pick < 54) begin
            c.mode = MODE_LEFT + MODE_W'($urandom_range(0, 3));
        end else if (pick < 60) begin
            c.mode = pick[0] ? MODE_ON : MODE_OFF;
        end else if (pick < 75) begin
            c.mode = MODE_TICK;
        end else if (pick < 97) begin
            c.mode = MODE_READ;
            pick   = $urandom_range(0, 19);
            if (pick < 14)
                c.cell_index = CELL_W'($urandom_range(0, cells - 1));
            else if (pick < 17)
                c.cell_index = CELL_W'(cursor_at & (cells - 1));
        end else begin
            c.mode = MODE_W'($urandom_range(MODE_SPARE_LOW, MODE_SPARE_TOP));
        end
        return c;
    endfunction

    // register values for each phase: extremes first, then small random grids
    function automatic reg_setting_t phase_setting(input int phase);
        reg_setting_t s;
        case (phase)
            1: s = '{3'd0, 3'd0, 16'h0000, 16'hFFFF, 16'h0000, 8'd1};
            2: s = '{3'd7, 3'd7, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd255};
            3: s = '{3'd0, 3'd7, 16'hA5A5, 16'h5A5A, 16'h0F0F, 8'd2};
            default: begin
                s.cols_log2 = 3'($urandom_range(0, 4));
                s.rows_log2 = 3'($urandom_range(0, 3));
                s.fill_fg   = COLOR_W'($urandom_range(0, 65535));
                s.fill_bg   = COLOR_W'($urandom_range(0, 65535));
                s.text_fg   = COLOR_W'($urandom_range(0, 65535));
                s.interval  = CHAR_W'($urandom_range(1, 255));
            end
        endcase
        return s;
    endfunction

    // send one command; its expectation is recorded at the accepting edge
    task automatic push_command(input term_cmd_t c, input logic typed, input cell_view_t fixed);
        cell_view_t v;
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, c.cell_index, c.symbol};
        s_tuser  = c.mode;
        do @(posedge aclk); while (!s_tready);
        v = terminal_step(c);
        expected_views.push_back(typed ? fixed : v);
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        shadow_register(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        term_cmd_t    cmd;
        term_cmd_t    plan [$];
        reg_setting_t setting;
        int unsigned  burst_left, sent, ticks, k, phase;
        logic         bursty;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed opening
        foreach (opening_script[r]) begin
            cmd = '{opening_script[r].mode, opening_script[r].symbol,
                    opening_script[r].cell_index};
            push_command(cmd, opening_script[r].typed, opening_script[r].want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            // reconfigure only once every pending result has drained
            if (phase != 0) begin
                s_tvalid = 1'b0;
                while (expected_views.size() != 0) @(negedge aclk);
                setting = phase_setting(phase);
                write_register(CFG_COLUMNS_LOG2,    {13'b0, setting.cols_log2});
                write_register(CFG_ROWS_LOG2,       {13'b0, setting.rows_log2});
                write_register(CFG_FILL_COLOR,      setting.fill_fg);
                write_register(CFG_FILL_BACKGROUND, setting.fill_bg);
                write_register(CFG_TEXT_COLOR,      setting.text_fg);
                write_register(CFG_BLINK_INTERVAL,  {8'b0, setting.interval});
            end
            bursty     = (phase % 3) != 1;
            burst_left = $urandom_range(1, 20);
            sent       = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // either a blink episode or a single random command
                if (plan.size() == 0) begin
                    if ($urandom_range(0, 11) == 0) begin
                        ticks = $urandom_range(1, 12);
                        cmd   = draw_command();
                        cmd.mode = MODE_ON;
                        plan.push_back(cmd);
                        for (k = 0; k < ticks; k++) begin
                            cmd.mode   = MODE_TICK;
                            cmd.symbol = CHAR_W'($urandom_range(0, 255));
                            plan.push_back(cmd);
                        end
                        cmd.mode       = MODE_READ;
                        cmd.cell_index = CELL_W'(cursor_at & (grid_cell_count() - 1));
                        plan.push_back(cmd);
                        cmd.mode = MODE_OFF;
                        plan.push_back(cmd);
                    end else begin
                        plan.push_back(draw_command());
                    end
                end
                cmd = plan.pop_front();
                if (bursty && burst_left == 0) begin
                    s_tvalid = 1'b0;
                    repeat ($urandom_range(1, 10)) @(negedge aclk);
                    burst_left = $urandom_range(1, 20);
                end
                push_command(cmd, 1'b0, '0);
                if (burst_left != 0)
                    burst_left--;
                sent++;
            end
        end

        // drain and settle
        s_tvalid = 1'b0;
        while (expected_views.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver backpressure: the style is drawn anew after each random span
    initial begin : sink_pacing
        int unsigned style, span, stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 96);
            repeat (span) begin
                @(negedge aclk);
                case (style)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 9) < 7);
                    2: m_tready = ~m_tready;
                    default: begin
                        if (stall_left != 0) begin
                            m_tready = 1'b0;
                            stall_left--;
                        end else begin
                            m_tready = 1'b1;
                            if ($urandom_range(0, 7) == 0)
                                stall_left = $urandom_range(5, 30);
                        end
                    end
                endcase
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // result checking against the oldest expectation
    always @(posedge aclk) begin : result_check
        cell_view_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_views.size() == 0) begin
                $error("result transaction with no expectation pending");
                fail_count++;
            end else begin
                want = expected_views.pop_front();
                check_field("cell_char",       want.char_code,  m_tdata[7:0]);
                check_field("cell_color",      want.color,      m_tdata[23:8]);
                check_field("cell_background", want.background, m_tdata[39:24]);
                check_field("cursor_index",    want.cursor,     m_tdata[50:40]);
                check_field("blink_active",    want.blink,      m_tdata[51]);
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

FILE: sim.f
sv/tte_pkg.sv
sv/tte_front.sv
sv/tte_queue.sv
sv/tte_back.sv
sv/text_terminal_engine.sv
tb/text_terminal_engine_tb.sv
